@@ sv/deq_pkg.sv @@
package deq_pkg;

    // Operation codes carried in a request
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_deq_op;

    // Status codes returned with each result
    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_deq_status;

    // Control sequencer states
    typedef enum logic {
        S_READY    = 1'b0,
        S_POP_READ = 1'b1
    } t_deq_state;

    // Input request
    typedef struct packed {
        t_deq_op            op;
        logic signed [31:0] value;
    } t_deq_req;

    // Result
    typedef struct packed {
        logic signed [31:0] popped_value;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [4:0]         entries_held;
        logic [31:0]        total_removed;
        t_deq_status        status;
    } t_deq_res;

endpackage

@@ sv/double_ended_queue.sv @@
// Bounded double-ended queue of signed 32-bit values held in a ring RAM.
//
// Input channel: i_in_valid / o_in_stall with request i_in_req (op, value).
// Ops push or pop at either end. Output channel: o_out_valid / i_out_stall
// with result o_out_res (popped value, new front and back values, entry
// count, running pop count, status). Every request yields one result.
//
// Timing: a push, a rejected request, or a pop that empties the queue
// registers its result at acceptance. Any other pop reads the new end
// entry from the registered RAM read port, gives its result from the
// read state and stalls the input there, so no new request is taken
// until it is done. Pushes go one per cycle unless the receiver stalls.
// The front and back values are cached in registers so only a pop needs
// a RAM read; a push writes its slot at the acceptance edge.
//
// Reset (synchronous, active low) empties the queue and clears the pop
// count; RAM contents are not cleared. When the receiver stalls with a
// result pending, the input stalls too until that result is taken.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  deq_pkg::t_deq_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output deq_pkg::t_deq_res o_out_res
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx);
        ring_prev = (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

    // Control and architectural state
    t_deq_state         r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [CW-1:0]      r_count, n_count;
    logic [31:0]        r_removed, n_removed;
    logic signed [31:0] r_front, n_front;
    logic signed [31:0] r_back, n_back;
    logic               r_out_valid, n_out_valid;

    // Payload registers
    t_deq_res           r_out, n_out;
    logic signed [31:0] r_pop_val, n_pop_val;
    logic               r_pop_back, n_pop_back;
    logic               r_one_left, n_one_left;

    // RAM port signals
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data;

    logic               in_acc;
    logic               ld_out;
    t_deq_res           res;

    deq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake
    assign o_in_stall  = (r_state == S_POP_READ) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // Next state, RAM access and result forming
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_removed  = r_removed;
        n_front    = r_front;
        n_back     = r_back;
        n_pop_val  = r_pop_val;
        n_pop_back = r_pop_back;
        n_one_left = r_one_left;
        wr_en      = 1'b0;
        wr_addr    = r_tail;
        wr_data    = i_in_req.value;
        rd_en      = 1'b0;
        rd_addr    = ring_next(r_head);
        ld_out     = 1'b0;
        res.popped_value = '0;
        res.status       = STS_DONE;

        case (r_state)
            S_READY: begin
                if (in_acc) begin
                    case (i_in_req.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            ld_out = 1'b1;
                            if (r_count == FULL_CNT) begin
                                res.status = STS_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                if (i_in_req.op == OP_PUSH_FRONT) begin
                                    n_head  = ring_prev(r_head);
                                    wr_addr = ring_prev(r_head);
                                    n_front = i_in_req.value;
                                    if (r_count == '0) begin
                                        n_back = i_in_req.value;
                                    end
                                end else begin
                                    n_tail  = ring_next(r_tail);
                                    wr_addr = r_tail;
                                    n_back  = i_in_req.value;
                                    if (r_count == '0) begin
                                        n_front = i_in_req.value;
                                    end
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (r_count == '0) begin
                                ld_out     = 1'b1;
                                res.status = STS_EMPTY;
                            end else begin
                                n_count   = r_count - 1'b1;
                                n_removed = r_removed + 32'd1;
                                if (i_in_req.op == OP_POP_FRONT) begin
                                    n_head    = ring_next(r_head);
                                    n_pop_val = r_front;
                                    rd_addr   = ring_next(r_head);
                                end else begin
                                    n_tail    = ring_prev(r_tail);
                                    n_pop_val = r_back;
                                    rd_addr   = ring_prev(ring_prev(r_tail));
                                end
                                n_pop_back = (i_in_req.op == OP_POP_BACK);
                                n_one_left = (r_count == CW'(2));
                                if (r_count == CW'(1)) begin
                                    // last entry leaves: queue is empty
                                    ld_out           = 1'b1;
                                    res.popped_value = n_pop_val;
                                    n_front          = '0;
                                    n_back           = '0;
                                end else begin
                                    rd_en   = 1'b1;
                                    n_state = S_POP_READ;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP_READ: begin
                // RAM returns the new end entry
                ld_out           = 1'b1;
                res.popped_value = r_pop_val;
                if (r_pop_back || r_one_left) begin
                    n_back = $signed(rd_data);
                end
                if (!r_pop_back || r_one_left) begin
                    n_front = $signed(rd_data);
                end
                n_state = S_READY;
            end
            default: begin
                n_state = S_READY;
            end
        endcase

        res.front_value   = n_front;
        res.back_value    = n_back;
        res.entries_held  = 5'(n_count);
        res.total_removed = n_removed;

        n_out_valid = ld_out || (r_out_valid && i_out_stall);
        n_out       = ld_out ? res : r_out;
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READY;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_removed   <= '0;
            r_front     <= '0;
            r_back      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_removed   <= n_removed;
            r_front     <= n_front;
            r_back      <= n_back;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_pop_val  <= n_pop_val;
        r_pop_back <= n_pop_back;
        r_one_left <= n_one_left;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == '0 && r_back == '0))
        else $error("cached ends not zero on empty queue");

    a_read_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_READ) |-> (o_in_stall && r_count != '0 && !r_out_valid))
        else $error("pop read cycle without stall or with pending result");

    a_pop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_req.op[1] && r_count != '0)
        |=> (r_removed == $past(r_removed) + 32'd1))
        else $error("removal count did not advance on pop");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_READ) |=> o_out_valid)
        else $error("pop read gave no result");
`endif

endmodule

@@ sv/deq_ram.sv @@
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ tb/sv/double_ended_queue_tb.sv @@
module double_ended_queue_tb;

    import deq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 300;
    localparam int MAX_PRINTS = 60;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    t_deq_req i_in_req    = '0;
    logic     i_out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_deq_res o_out_res;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_res  (o_out_res)
    );

    // Clock: period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the queue
    logic signed [31:0] ring_m [DEPTH];
    int                 head_m    = 0;
    int                 tail_m    = 0;
    int                 held_m    = 0;
    logic [31:0]        removed_m = '0;

    t_deq_res deq_expected[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_ask       = 0;
    int err_count      = 0;
    int n_sent         = 0;
    int n_checked      = 0;
    int n_full_drops   = 0;
    int n_empty_pops   = 0;
    int n_holds        = 0;

    // Next state and result of the queue for one request
    function automatic t_deq_res deq_predict(t_deq_req r);
        t_deq_res res;
        res        = '0;
        res.status = STS_DONE;
        if (r.op == OP_PUSH_FRONT || r.op == OP_PUSH_BACK) begin
            if (held_m >= DEPTH) begin
                res.status = STS_FULL;
            end else if (r.op == OP_PUSH_FRONT) begin
                head_m         = (head_m + DEPTH - 1) % DEPTH;
                ring_m[head_m] = r.value;
                held_m++;
            end else begin
                ring_m[tail_m] = r.value;
                tail_m         = (tail_m + 1) % DEPTH;
                held_m++;
            end
        end else begin
            if (held_m == 0) begin
                res.status = STS_EMPTY;
            end else if (r.op == OP_POP_FRONT) begin
                res.popped_value = ring_m[head_m];
                head_m           = (head_m + 1) % DEPTH;
                held_m--;
                removed_m++;
            end else begin
                tail_m           = (tail_m + DEPTH - 1) % DEPTH;
                res.popped_value = ring_m[tail_m];
                held_m--;
                removed_m++;
            end
        end
        if (held_m != 0) begin
            res.front_value = ring_m[head_m];
            res.back_value  = ring_m[(tail_m + DEPTH - 1) % DEPTH];
        end
        res.entries_held  = held_m[4:0];
        res.total_removed = removed_m;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("MISMATCH result %0d %s: got %0h expected %0h",
                     n_checked, what, got, want);
    endtask

    // Offer one request; returns at the edge that accepts it
    task automatic send_request(t_deq_op op, logic signed [31:0] v);
        t_deq_req r;
        bit       took;
        r.op    = op;
        r.value = v;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do begin
            @(negedge i_clk);
            took = !o_in_stall;
            if (took) begin
                t_deq_res want;
                want = deq_predict(r);
                if (want.status == STS_FULL) n_full_drops++;
                if (want.status == STS_EMPTY) n_empty_pops++;
                deq_expected.push_back(want);
                n_sent++;
            end
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (deq_expected.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_deq_op pick_op(int push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    // Receiver stall, with a long hold-off on request
    initial begin : out_stall_gen
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_ask != 0) begin
                hold_left = hold_ask;
                hold_ask  = 0;
                n_holds++;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Result checker
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (deq_expected.size() == 0) begin
                report_mismatch("unexpected result", o_out_res.popped_value, '0);
            end else begin
                t_deq_res want;
                want = deq_expected.pop_front();
                if (o_out_res.popped_value !== want.popped_value)
                    report_mismatch("popped_value", o_out_res.popped_value,
                                    want.popped_value);
                if (o_out_res.front_value !== want.front_value)
                    report_mismatch("front_value", o_out_res.front_value,
                                    want.front_value);
                if (o_out_res.back_value !== want.back_value)
                    report_mismatch("back_value", o_out_res.back_value,
                                    want.back_value);
                if (o_out_res.entries_held !== want.entries_held)
                    report_mismatch("entries_held", 32'(o_out_res.entries_held),
                                    32'(want.entries_held));
                if (o_out_res.total_removed !== want.total_removed)
                    report_mismatch("total_removed", o_out_res.total_removed,
                                    want.total_removed);
                if (o_out_res.status !== want.status)
                    report_mismatch("status", 32'(o_out_res.status),
                                    32'(want.status));
            end
            n_checked++;
        end
    end

    // Watchdog: cycles with no transfer on either channel
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else if (deq_expected.size() != 0 || i_in_valid)
                idle_cycles++;
            else
                idle_cycles = 0;
        end
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Empty pops, single-element pops at both ends, value extremes
    task automatic test_directed();
        send_request(OP_POP_FRONT, 32'sh7FFF_FFFF);
        send_request(OP_POP_BACK, 32'sh8000_0000);
        send_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
        send_request(OP_POP_BACK, '0);
        send_request(OP_PUSH_FRONT, 32'sh8000_0000);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_PUSH_FRONT, -32'sd1);
        send_request(OP_PUSH_BACK, 32'sh0000_0000);
        send_request(OP_PUSH_FRONT, 32'sh5555_AAAA);
        send_request(OP_POP_BACK, -32'sd1);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_BACK, '0);
        wait_drained();
    endtask

    // Fill to full, push on full at both ends, drain to empty, pop on empty at both ends
    task automatic test_fill_drain();
        repeat (DEPTH) send_request(pick_op(100), pick_value());
        send_request(OP_PUSH_FRONT, pick_value());
        send_request(OP_PUSH_BACK, pick_value());
        repeat (DEPTH) send_request(pick_op(0), pick_value());
        send_request(OP_POP_FRONT, pick_value());
        send_request(OP_POP_BACK, pick_value());
        wait_drained();
    endtask

    // Receiver holds off while requests keep coming
    task automatic test_backpressure();
        hold_ask = HOLD_LEN;
        repeat (40) send_request(pick_op(75), pick_value());
        wait_drained();
    endtask

    // Random requests in streaks that lean toward popping, stay even, or lean toward pushing
    task automatic test_random(int n, int sidle, int rstall);
        int push_pct;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        push_pct       = 50;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 80;
                endcase
            end
            send_request(pick_op(push_pct), pick_value());
        end
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_drain();
        test_backpressure();
        test_random(350, 0, 0);
        test_random(350, 48, 0);
        test_random(350, 0, 48);
        test_random(350, 14, 14);

        // let any stray result show up
        repeat (10) @(posedge i_clk);
        if (deq_expected.size() != 0)
            report_mismatch("results missing at end", deq_expected.size(), 0);

        $display("Sent %0d requests, checked %0d results, %0d long receiver hold-offs",
                 n_sent, n_checked, n_holds);
        $display("Dropped pushes on full: %0d, pops on empty: %0d, mismatches: %0d",
                 n_full_drops, n_empty_pops, err_count);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
